[design/vmtd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmtd_pkg
// types, codes and arithmetic constants shared by the vibration motor drive
// ----------------------------------------------------------------------------
package vmtd_pkg;

  localparam int MODE_W     = 2;
  localparam int LEVEL_W    = 8;
  localparam int DUR_W      = 16;
  localparam int PERIOD_W   = 16;
  localparam int DUTY_W     = 16;
  localparam int TICKS_W    = 14;
  localparam int LVL_EFF_W  = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int LEVEL_MAX   = 100;
  localparam int LEVEL_FLOOR = 10;
  localparam int TICK_MS     = 5;

  // period * level, level at most 100
  localparam int PRODUCT_W = PERIOD_W + LVL_EFF_W;
  // exact x / 100 for x below 2^30 / 76
  localparam int RECIP100_W  = 24;
  localparam int RECIP100    = 10737419;
  localparam int RECIP100_SH = 30;
  localparam int QPROD_W     = PRODUCT_W + RECIP100_W;
  // exact z / 5 for z below 2^18
  localparam int MSP_W     = DUR_W + 1;
  localparam int RECIP5_W  = 17;
  localparam int RECIP5    = 104858;
  localparam int RECIP5_SH = 19;
  localparam int TPROD_W   = MSP_W + RECIP5_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_ON      = 2'd0,
    MODE_OFF     = 2'd1,
    MODE_VIBRATE = 2'd2,
    MODE_TICK    = 2'd3
  } mode_t;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_PWM_TOP     = 2'd0;
  localparam cfg_idx_t CFG_DRIVE_ALLOW = 2'd1;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd24000;

  typedef struct packed {
    logic [PERIOD_W-1:0] pwm_top;
    logic                drive_allow;
  } vmtd_cfg_t;

  typedef struct packed {
    mode_t              mode;
    logic [LEVEL_W-1:0] level;
    logic [DUR_W-1:0]   duration_ms;
  } vmtd_cmd_t;

  // arithmetic results handed to the state stage
  typedef struct packed {
    mode_t              mode;
    logic [DUTY_W-1:0]  quot;
    logic [TICKS_W-1:0] ticks;
  } vmtd_work_t;

endpackage

[design/vmtd_channels.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmtd channels
// valid/ready channel interfaces for commands, results and register writes
// ----------------------------------------------------------------------------
interface vmtd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  level;
  logic [15:0] duration_ms;
  modport source (output valid, output mode, output level, output duration_ms, input ready);
  modport sink   (input valid, input mode, input level, input duration_ms, output ready);
endinterface

interface vmtd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] duty;
  logic        drive_enable;
  logic        duty_write;
  logic        period_reload;
  logic        buzz_mute;
  logic        run_flag;
  logic        timed_active;
  modport source (output valid, output duty, output drive_enable, output duty_write,
                  output period_reload, output buzz_mute, output run_flag,
                  output timed_active, input ready);
  modport sink   (input valid, input duty, input drive_enable, input duty_write,
                  input period_reload, input buzz_mute, input run_flag,
                  input timed_active, output ready);
endinterface

interface vmtd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[design/vmtd_duty_calc.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmtd_duty_calc
// command register, period*level product, constant divides by 100 and by 5
// ----------------------------------------------------------------------------
module vmtd_duty_calc (
  input  logic                  clk,
  input  logic                  rst_n,
  vmtd_in_if.sink               in_if,
  input  logic [15:0]           pwm_top,
  output logic                  work_valid,
  input  logic                  work_ready,
  output vmtd_pkg::vmtd_work_t  work
);
  import vmtd_pkg::*;

  logic                 v1_r, v2_r, v3_r;
  logic                 rdy1, rdy2;
  vmtd_cmd_t            cmd_r;
  mode_t                mode2_r;
  logic [PRODUCT_W-1:0] prod_r, prod_nxt;
  logic [MSP_W-1:0]     msp_r, msp_nxt;
  logic [LVL_EFF_W-1:0] lvl1;
  logic [QPROD_W-1:0]   qprod;
  logic [TPROD_W-1:0]   tprod;
  vmtd_work_t           work_r;

  assign rdy2        = !v3_r || work_ready;
  assign rdy1        = !v2_r || rdy2;
  assign in_if.ready = !v1_r || rdy1;

  // clamp to 100, vibrate raises zero to the floor level
  always_comb begin
    if (cmd_r.level > LEVEL_W'(LEVEL_MAX)) begin
      lvl1 = LVL_EFF_W'(LEVEL_MAX);
    end else if (cmd_r.mode == MODE_VIBRATE && cmd_r.level == '0) begin
      lvl1 = LVL_EFF_W'(LEVEL_FLOOR);
    end else begin
      lvl1 = cmd_r.level[LVL_EFF_W-1:0];
    end
  end

  assign prod_nxt = PRODUCT_W'(pwm_top) * PRODUCT_W'(lvl1);
  assign msp_nxt  = MSP_W'(cmd_r.duration_ms) + MSP_W'(TICK_MS - 1);

  assign qprod = QPROD_W'(prod_r) * QPROD_W'(RECIP100);
  assign tprod = TPROD_W'(msp_r) * TPROD_W'(RECIP5);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (in_if.ready) begin
        v1_r <= in_if.valid;
      end
      if (rdy1) begin
        v2_r <= v1_r;
      end
      if (rdy2) begin
        v3_r <= v2_r;
      end
    end
    if (in_if.ready && in_if.valid) begin
      cmd_r.mode        <= mode_t'(in_if.mode);
      cmd_r.level       <= in_if.level;
      cmd_r.duration_ms <= in_if.duration_ms;
    end
    if (rdy1) begin
      mode2_r <= cmd_r.mode;
      prod_r  <= prod_nxt;
      msp_r   <= msp_nxt;
    end
    if (rdy2) begin
      work_r.mode  <= mode2_r;
      work_r.quot  <= qprod[RECIP100_SH +: DUTY_W];
      work_r.ticks <= tprod[RECIP5_SH +: TICKS_W];
    end
  end

  assign work_valid = v3_r;
  assign work       = work_r;

endmodule

[design/vmtd_state_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmtd_state_ctrl
// motor on/timed state, duty register and registered result
// ----------------------------------------------------------------------------
module vmtd_state_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  work_valid,
  output logic                  work_ready,
  input  vmtd_pkg::vmtd_work_t  work,
  input  vmtd_pkg::vmtd_cfg_t   cfg,
  vmtd_out_if.source            out_if
);
  import vmtd_pkg::*;

  logic               on_r, on_nxt;
  logic               timed_r, timed_nxt;
  logic [TICKS_W-1:0] ticks_r, ticks_nxt;
  logic [DUTY_W-1:0]  duty_r, duty_nxt;
  logic               dw, pr, bs;
  logic [DUTY_W-1:0]  duty_lim;
  logic [TICKS_W-1:0] tick_dec;
  logic               take;

  logic               ov_r;
  logic [DUTY_W-1:0]  o_duty_r;
  logic               o_on_r, o_dw_r, o_pr_r, o_bs_r, o_timed_r;

  assign work_ready = !ov_r || out_if.ready;
  assign take       = work_valid && work_ready;

  always_comb begin
    if (cfg.pwm_top == '0) begin
      duty_lim = '0;
    end else if (work.quot >= cfg.pwm_top) begin
      duty_lim = cfg.pwm_top - 16'd1;
    end else begin
      duty_lim = work.quot;
    end
    tick_dec = (ticks_r != '0) ? ticks_r - TICKS_W'(1) : ticks_r;
  end

  always_comb begin
    on_nxt    = on_r;
    timed_nxt = timed_r;
    ticks_nxt = ticks_r;
    duty_nxt  = duty_r;
    dw        = 1'b0;
    pr        = 1'b0;
    bs        = 1'b0;
    unique case (work.mode)
      MODE_ON, MODE_VIBRATE: begin
        timed_nxt = 1'b0;
        ticks_nxt = '0;
        bs        = 1'b1;
        if (cfg.drive_allow) begin
          pr       = 1'b1;
          dw       = 1'b1;
          duty_nxt = duty_lim;
          on_nxt   = 1'b1;
        end else begin
          on_nxt = 1'b0;
        end
        if (work.mode == MODE_VIBRATE) begin
          ticks_nxt = (work.ticks == '0) ? TICKS_W'(1) : work.ticks;
          timed_nxt = 1'b1;
        end
      end
      MODE_OFF: begin
        timed_nxt = 1'b0;
        ticks_nxt = '0;
        on_nxt    = 1'b0;
      end
      MODE_TICK: begin
        if (timed_r) begin
          ticks_nxt = tick_dec;
          if (tick_dec == '0) begin
            timed_nxt = 1'b0;
            on_nxt    = 1'b0;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_r    <= 1'b0;
      timed_r <= 1'b0;
      ticks_r <= '0;
      duty_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      if (work_ready) begin
        ov_r <= work_valid;
      end
      if (take) begin
        on_r    <= on_nxt;
        timed_r <= timed_nxt;
        ticks_r <= ticks_nxt;
        duty_r  <= duty_nxt;
      end
    end
    if (take) begin
      o_duty_r  <= duty_nxt;
      o_on_r    <= on_nxt;
      o_dw_r    <= dw;
      o_pr_r    <= pr;
      o_bs_r    <= bs;
      o_timed_r <= timed_nxt;
    end
  end

  assign out_if.valid         = ov_r;
  assign out_if.duty          = o_duty_r;
  assign out_if.drive_enable  = o_on_r;
  assign out_if.duty_write    = o_dw_r;
  assign out_if.period_reload = o_pr_r;
  assign out_if.buzz_mute     = o_bs_r;
  assign out_if.run_flag      = o_on_r;
  assign out_if.timed_active  = o_timed_r;

endmodule

[design/vibration_motor_timed_drive.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vibration_motor_timed_drive
// command driven vibration motor control: duty, drive enable and timed run
// ----------------------------------------------------------------------------
// throughput: one command per cycle while results are taken, through the
//   three-register pipeline (command, product, reciprocal divide) that
//   feeds a registered state update
// reset: on flag, countdown and duty clear to 0, pwm top to 24000,
//   drive allow to 1, pipeline and result register empty
// ----------------------------------------------------------------------------
module vibration_motor_timed_drive (
  input  logic      clk,
  input  logic      rst_n,
  vmtd_in_if.sink   in_if,
  vmtd_out_if.source out_if,
  vmtd_cfg_if.sink  cfg_if
);
  import vmtd_pkg::*;

  // configuration registers
  vmtd_cfg_t cfg_r;

  // pipeline to state stage
  logic       work_valid;
  logic       work_ready;
  vmtd_work_t work;

  // transactions accepted but not yet delivered, used by the checks below
  logic [2:0] inflight_r;

  // register writes are always taken
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pwm_top     <= PERIOD_RESET;
      cfg_r.drive_allow <= 1'b1;
    end else if (cfg_if.valid && cfg_if.ready) begin
      unique case (cfg_if.index)
        CFG_PWM_TOP:     cfg_r.pwm_top     <= cfg_if.data;
        CFG_DRIVE_ALLOW: cfg_r.drive_allow <= cfg_if.data[0];
        default: begin
          // unmapped index, write ignored
        end
      endcase
    end
  end

  // product and constant divides, independent of motor state
  vmtd_duty_calc u_calc (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .pwm_top    (cfg_r.pwm_top),
    .work_valid (work_valid),
    .work_ready (work_ready),
    .work       (work)
  );

  // state update and result register
  vmtd_state_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .work_valid (work_valid),
    .work_ready (work_ready),
    .work       (work),
    .cfg        (cfg_r),
    .out_if     (out_if)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_r
                    + 3'((in_if.valid && in_if.ready) ? 1 : 0)
                    - 3'((out_if.valid && out_if.ready) ? 1 : 0);
    end
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------

  // a duty write only comes with a reload, a buzzer mute and the motor running
  a_duty_write_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.duty_write |->
      out_if.period_reload && out_if.buzz_mute && out_if.run_flag)
    else $error("duty write without reload, buzzer mute or motor running");

  // the pipeline holds at most four transactions
  a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= 3'd4)
    else $error("more transactions in flight than pipeline stages");

  // a result is never shown without an accepted command behind it
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> inflight_r != 3'd0)
    else $error("result valid with no transaction in flight");

  // an empty block shows no result
  a_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r == 3'd0 |-> !out_if.valid && !work_valid)
    else $error("pipeline holds data while empty");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vibration motor drive testbench
// directed and random command streams checked field by field against a
// cycle-free model of the motor state, with register changes between phases
// ----------------------------------------------------------------------------
module tb;
  import vmtd_pkg::*;

  // spare register indexes, writes there must change nothing
  localparam cfg_idx_t CFG_SPARE_2 = 2'd2;
  localparam cfg_idx_t CFG_SPARE_3 = 2'd3;

  // field order matches the concatenation used by the result monitor
  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              drive_enable;
    logic              duty_write;
    logic              period_reload;
    logic              buzz_mute;
    logic              run_flag;
    logic              timed_active;
  } motor_status_t;

  // predicted motor state plus the queue of statuses still owed by the block
  class motor_scoreboard;
    motor_status_t       owed_status[$];
    logic [PERIOD_W-1:0] period;
    logic                enable;
    logic                on_flag;
    logic                timed_flag;
    logic [TICKS_W-1:0]  ticks;
    logic [DUTY_W-1:0]   duty;
    int unsigned         failures;

    function new();
      period     = PERIOD_RESET;
      enable     = 1'b1;
      on_flag    = 1'b0;
      timed_flag = 1'b0;
      ticks      = '0;
      duty       = '0;
      failures   = 0;
    endfunction

    function int pending();
      return owed_status.size();
    endfunction

    function void flag_error(string msg);
      failures++;
      if (failures <= 10) $display("tb: %s", msg);
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_PWM_TOP:     period = data;
        CFG_DRIVE_ALLOW: enable = data[0];
        default: ;
      endcase
    endfunction

    function void shut_down();
      timed_flag = 1'b0;
      ticks      = '0;
      on_flag    = 1'b0;
    endfunction

    // on path shared by turn-on and timed vibrate
    function void power_up(logic [LEVEL_W-1:0] level, inout motor_status_t st);
      logic [LVL_EFF_W-1:0] lvl;
      logic [PRODUCT_W-1:0] prod;
      logic [PRODUCT_W-1:0] quot;
      lvl = (level > LEVEL_MAX) ? LVL_EFF_W'(LEVEL_MAX) : level[LVL_EFF_W-1:0];
      timed_flag   = 1'b0;
      ticks        = '0;
      st.buzz_mute = 1'b1;
      if (!enable) begin
        on_flag = 1'b0;
      end else begin
        prod = PRODUCT_W'(period) * PRODUCT_W'(lvl);
        quot = PRODUCT_W'(prod / LEVEL_MAX);
        if (period == 0) duty = '0;
        else if (quot >= period) duty = period - 1'b1;
        else duty = quot[DUTY_W-1:0];
        st.period_reload = 1'b1;
        st.duty_write    = 1'b1;
        on_flag          = 1'b1;
      end
    endfunction

    function void note_command(mode_t mode, logic [LEVEL_W-1:0] level,
                               logic [DUR_W-1:0] dur);
      motor_status_t   st;
      logic [MSP_W-1:0] span;
      st = '0;
      case (mode)
        MODE_ON:  power_up(level, st);
        MODE_OFF: shut_down();
        MODE_VIBRATE: begin
          power_up((level == 0) ? LEVEL_W'(LEVEL_FLOOR) : level, st);
          span = (MSP_W'(dur) + MSP_W'(TICK_MS - 1)) / MSP_W'(TICK_MS);
          if (span == 0) span = 1;
          ticks      = span[TICKS_W-1:0];
          timed_flag = 1'b1;
        end
        MODE_TICK: begin
          if (timed_flag) begin
            if (ticks != 0) ticks = ticks - 1'b1;
            if (ticks == 0) shut_down();
          end
        end
        default: ;
      endcase
      st.duty         = duty;
      st.drive_enable = on_flag;
      st.run_flag     = on_flag;
      st.timed_active = timed_flag;
      owed_status.push_back(st);
    endfunction

    function void compare_field(string what, logic [DUTY_W-1:0] want,
                                logic [DUTY_W-1:0] got);
      if (got !== want)
        flag_error($sformatf("%s mismatch: expected %0d, got %0d", what, want, got));
    endfunction

    function void check_result(motor_status_t got);
      motor_status_t want;
      if (owed_status.size() == 0) begin
        flag_error("result transaction with nothing outstanding");
      end else begin
        want = owed_status.pop_front();
        compare_field("duty", want.duty, got.duty);
        compare_field("drive_enable", DUTY_W'(want.drive_enable),
                      DUTY_W'(got.drive_enable));
        compare_field("duty_write", DUTY_W'(want.duty_write),
                      DUTY_W'(got.duty_write));
        compare_field("period_reload", DUTY_W'(want.period_reload),
                      DUTY_W'(got.period_reload));
        compare_field("buzz_mute", DUTY_W'(want.buzz_mute),
                      DUTY_W'(got.buzz_mute));
        compare_field("run_flag", DUTY_W'(want.run_flag),
                      DUTY_W'(got.run_flag));
        compare_field("timed_active", DUTY_W'(want.timed_active),
                      DUTY_W'(got.timed_active));
      end
    endfunction

    function void close_out();
      if (owed_status.size() != 0)
        flag_error($sformatf("%0d results never arrived", owed_status.size()));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  // idling knobs, percent per transaction on the send side and per cycle
  // on the receive side
  int gap_pct;
  int stall_pct;

  motor_scoreboard sb;

  vmtd_in_if  in_ch ();
  vmtd_out_if out_ch ();
  vmtd_cfg_if cfg_ch ();

  vibration_motor_timed_drive u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always #10 clk = ~clk;

  // all three channels are observed at the edge, before any update lands
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.write_reg(cfg_ch.index, cfg_ch.data);
      if (in_ch.valid && in_ch.ready)
        sb.note_command(mode_t'(in_ch.mode), in_ch.level, in_ch.duration_ms);
      if (out_ch.valid && out_ch.ready)
        sb.check_result({out_ch.duty, out_ch.drive_enable, out_ch.duty_write,
                         out_ch.period_reload, out_ch.buzz_mute,
                         out_ch.run_flag, out_ch.timed_active});
    end
  end

  // result side back-pressure in random bursts
  initial begin : sink_side
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 15);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // hard stop in case the block hangs
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  // one command transaction, then maybe an idle burst with junk on the bus
  task automatic send_command(mode_t mode, logic [LEVEL_W-1:0] level,
                              logic [DUR_W-1:0] dur);
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= mode;
    in_ch.level       <= level;
    in_ch.duration_ms <= dur;
    do @(posedge clk); while (!in_ch.ready);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_ch.valid       <= 1'b0;
      in_ch.mode        <= MODE_W'($urandom);
      in_ch.level       <= LEVEL_W'($urandom);
      in_ch.duration_ms <= DUR_W'($urandom);
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // leaves valid high, the caller lowers it after the last write
  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // stop sending and wait until every owed result has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [LEVEL_W-1:0] pick_level();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return LEVEL_W'(LEVEL_MAX);
      2:       return LEVEL_W'($urandom_range(LEVEL_MAX + 1, 255));
      3:       return '1;
      default: return LEVEL_W'($urandom_range(0, LEVEL_MAX));
    endcase
  endfunction

  // mostly short runs so countdowns finish, now and then long ones
  function automatic logic [DUR_W-1:0] pick_duration();
    case ($urandom_range(0, 9))
      0:       return DUR_W'($urandom);
      1:       return DUR_W'($urandom_range(65530, 65535));
      default: return DUR_W'($urandom_range(0, 60));
    endcase
  endfunction

  function automatic logic [PERIOD_W-1:0] pick_period();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return PERIOD_W'(1);
      2:       return PERIOD_W'(2);
      3:       return '1;
      4:       return PERIOD_RESET;
      5, 6:    return PERIOD_W'($urandom_range(3, 200));
      default: return PERIOD_W'($urandom);
    endcase
  endfunction

  // a timed run followed by ticks, around its expiry for short runs, or a single command
  task automatic random_burst(output int n);
    int                 r;
    int                 span;
    int                 taps;
    logic [DUR_W-1:0]   ms;
    r = $urandom_range(0, 99);
    n = 1;
    if (r < 40) begin
      ms = pick_duration();
      send_command(MODE_VIBRATE, pick_level(), ms);
      span = (int'(ms) + TICK_MS - 1) / TICK_MS;
      if (span == 0) span = 1;
      if (span > 12) taps = $urandom_range(0, 6);
      else taps = $urandom_range(span - 1, span + 1);
      for (int k = 0; k < taps; k++) begin
        // on or off cut the countdown short now and then
        if ($urandom_range(0, 19) == 0)
          send_command($urandom_range(0, 1) ? MODE_ON : MODE_OFF, pick_level(),
                       DUR_W'($urandom));
        else
          send_command(MODE_TICK, LEVEL_W'($urandom), DUR_W'($urandom));
        n++;
      end
    end else if (r < 65) begin
      send_command(MODE_ON, pick_level(), DUR_W'($urandom));
    end else if (r < 75) begin
      send_command(MODE_OFF, LEVEL_W'($urandom), DUR_W'($urandom));
    end else if (r < 85) begin
      send_command(MODE_VIBRATE, pick_level(), DUR_W'($urandom));
    end else begin
      send_command(MODE_TICK, LEVEL_W'($urandom), DUR_W'($urandom));
    end
  endtask

  initial begin : stimulus
    int  sent;
    int  n;
    bit  paused;
    sb        = new();
    gap_pct   = 20;
    stall_pct = 10;
    paused    = 1'b0;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.mode         <= MODE_OFF;
    in_ch.level        <= '0;
    in_ch.duration_ms  <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= CFG_PWM_TOP;
    cfg_ch.data        <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: level extremes, clamp, idle tick, countdown edges
    send_command(MODE_ON, 8'd0, 16'd0);
    send_command(MODE_ON, 8'd100, 16'd0);
    send_command(MODE_ON, 8'd255, 16'hffff);
    send_command(MODE_ON, 8'd50, 16'd0);
    send_command(MODE_OFF, 8'd0, 16'd0);
    send_command(MODE_TICK, 8'd0, 16'd0);
    // zero level and zero duration: floor level, one tick
    send_command(MODE_VIBRATE, 8'd0, 16'd0);
    send_command(MODE_TICK, 8'd0, 16'd0);
    // longest duration, count must not wrap
    send_command(MODE_VIBRATE, 8'd101, 16'hffff);
    send_command(MODE_TICK, 8'd0, 16'd0);
    // turning on cancels the countdown
    send_command(MODE_ON, 8'd30, 16'd0);
    // 11 ms rounds up to three ticks
    send_command(MODE_VIBRATE, 8'd7, 16'd11);
    repeat (3) send_command(MODE_TICK, 8'd0, 16'd0);

    // drive disabled: buzzer only, countdown still armed and still expires
    drain_results();
    write_reg(CFG_DRIVE_ALLOW, 16'd0);
    cfg_ch.valid <= 1'b0;
    send_command(MODE_ON, 8'd60, 16'd0);
    send_command(MODE_VIBRATE, 8'd0, 16'd5);
    send_command(MODE_TICK, 8'd0, 16'd0);

    // disable while running only bites on the next turn-on
    drain_results();
    write_reg(CFG_DRIVE_ALLOW, 16'd1);
    cfg_ch.valid <= 1'b0;
    send_command(MODE_ON, 8'd40, 16'd0);
    drain_results();
    write_reg(CFG_DRIVE_ALLOW, 16'hfffe);
    cfg_ch.valid <= 1'b0;
    send_command(MODE_TICK, 8'd0, 16'd0);
    send_command(MODE_ON, 8'd20, 16'd0);

    // spare indexes, then the tiny and the largest periods
    drain_results();
    write_reg(CFG_SPARE_2, 16'hffff);
    write_reg(CFG_SPARE_3, 16'h5a5a);
    write_reg(CFG_PWM_TOP, 16'd0);
    write_reg(CFG_DRIVE_ALLOW, 16'h8001);
    cfg_ch.valid <= 1'b0;
    send_command(MODE_ON, 8'd100, 16'd0);
    drain_results();
    write_reg(CFG_PWM_TOP, 16'd1);
    cfg_ch.valid <= 1'b0;
    send_command(MODE_ON, 8'd100, 16'd0);
    drain_results();
    write_reg(CFG_PWM_TOP, 16'hffff);
    cfg_ch.valid <= 1'b0;
    send_command(MODE_ON, 8'd100, 16'd0);
    send_command(MODE_ON, 8'd99, 16'd0);

    // random phases, each with its own register setting and idling mix
    for (int phase = 0; phase < 14; phase++) begin
      drain_results();
      if (phase == 13) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0:       gap_pct = 0;
          1:       gap_pct = 15;
          default: gap_pct = 40;
        endcase
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 5;
          default: stall_pct = 15;
        endcase
      end
      if ($urandom_range(0, 1)) begin
        write_reg(CFG_PWM_TOP, pick_period());
        write_reg(CFG_DRIVE_ALLOW, {15'($urandom), $urandom_range(0, 4) != 0});
      end else begin
        write_reg(CFG_DRIVE_ALLOW, {15'($urandom), $urandom_range(0, 4) != 0});
        write_reg(CFG_PWM_TOP, pick_period());
      end
      if ($urandom_range(0, 5) == 0)
        write_reg(cfg_idx_t'($urandom_range(2, 3)), CFG_DATA_W'($urandom));
      cfg_ch.valid <= 1'b0;
      sent = 0;
      while (sent < 110) begin
        // let the pipeline run dry once in the middle of a phase
        if (phase == 6 && sent >= 50 && !paused) begin
          drain_results();
          paused = 1'b1;
        end
        random_burst(n);
        sent += n;
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    sb.close_out();
    if (sb.failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sim.f]
design/vmtd_pkg.sv
design/vmtd_channels.sv
design/vmtd_duty_calc.sv
design/vmtd_state_ctrl.sv
design/vibration_motor_timed_drive.sv
tb/tb.sv
